### rtl/tdp_pkg.sv
`default_nettype none

package tdp_pkg;

    localparam int WIDTH = 32;
    // the divisor never passes floor(sqrt(2^(WIDTH-1))) + 1
    localparam int DIV_W = WIDTH / 2;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_REPORT
    } tdp_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic advance;
    } tdp_cmd_t;

    typedef struct packed {
        logic square_exceeds;
        logic mag_gt_one;
        logic count_last;
        logic rem_zero;
    } tdp_status_t;

endpackage

`default_nettype wire

### rtl/tdp_datapath.sv
`default_nettype none

module tdp_datapath
    import tdp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic signed [WIDTH-1:0] value,
    input  wire tdp_cmd_t                cmd,
    output tdp_status_t                  status
);

    logic [WIDTH-1:0] magnitude_reg, magnitude_next;
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    logic [WIDTH-1:0] divisor_square_reg, divisor_square_next;
    logic [DIV_W-1:0] partial_remainder_reg, partial_remainder_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [WIDTH-1:0] abs_value;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   trial_diff;
    logic [DIV_W-1:0] rem_step;
    logic [WIDTH-1:0] square_inc;

    // most negative value wraps to 2^(WIDTH-1), which fits unsigned
    assign abs_value = value[WIDTH-1] ? (~value + 1'b1) : value;

    // one restoring division step, magnitude bits fed from the top
    assign trial      = {partial_remainder_reg, magnitude_reg[count_reg]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign rem_step   = (trial >= {1'b0, divisor_reg}) ? trial_diff[DIV_W-1:0]
                                                       : trial[DIV_W-1:0];

    // (d+1)^2 = d^2 + 2d + 1
    assign square_inc = {{(WIDTH-DIV_W-1){1'b0}}, divisor_reg, 1'b1};

    always_comb
    begin
        magnitude_next         = magnitude_reg;
        divisor_next           = divisor_reg;
        divisor_square_next    = divisor_square_reg;
        partial_remainder_next = partial_remainder_reg;
        count_next             = count_reg;
        if (cmd.load)
        begin
            magnitude_next         = abs_value;
            divisor_next           = DIV_W'(2);
            divisor_square_next    = WIDTH'(4);
            partial_remainder_next = '0;
        end
        if (cmd.div_start)
        begin
            partial_remainder_next = '0;
            count_next             = CNT_W'(WIDTH - 1);
        end
        if (cmd.div_step)
        begin
            partial_remainder_next = rem_step;
            count_next             = count_reg - 1'b1;
        end
        if (cmd.advance)
        begin
            divisor_next        = divisor_reg + 1'b1;
            divisor_square_next = divisor_square_reg + square_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnitude_reg         <= '0;
            divisor_reg           <= DIV_W'(2);
            divisor_square_reg    <= WIDTH'(4);
            partial_remainder_reg <= '0;
            count_reg             <= '0;
        end
        else
        begin
            magnitude_reg         <= magnitude_next;
            divisor_reg           <= divisor_next;
            divisor_square_reg    <= divisor_square_next;
            partial_remainder_reg <= partial_remainder_next;
            count_reg             <= count_next;
        end
    end

    assign status.square_exceeds = (divisor_square_reg > magnitude_reg);
    assign status.mag_gt_one     = (magnitude_reg > WIDTH'(1));
    assign status.count_last     = (count_reg == '0);
    assign status.rem_zero       = (rem_step == '0);

endmodule

`default_nettype wire

### rtl/tdp_controller.sv
`default_nettype none

module tdp_controller
    import tdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire tdp_status_t status,
    output tdp_cmd_t         cmd,
    output logic             busy,
    output logic             done,
    output logic             is_prime
);

    tdp_state_t state_reg, state_next;
    logic       prime_reg, prime_next;

    always_comb
    begin
        state_next = state_reg;
        prime_next = prime_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.square_exceeds)
                begin
                    state_next = ST_REPORT;
                    prime_next = status.mag_gt_one;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.count_last)
                begin
                    if (status.rem_zero)
                    begin
                        state_next = ST_REPORT;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_CHECK:
            begin
                cmd.div_start = !status.square_exceeds;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cmd.advance  = status.count_last && !status.rem_zero;
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prime_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prime_reg <= prime_next;
        end
    end

    assign is_prime = prime_reg;

`ifndef SYNTHESIS
    // an accepted item always starts a search
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start a search");

    // one strobe per item, then idle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // a new divisor is only tried after its predecessor passed the bound
    a_advance_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> !status.square_exceeds)
        else $error("divisor advanced past the bound");

    // prime verdict only possible when magnitude exceeds one
    a_prime_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_prime) |-> status.mag_gt_one)
        else $error("prime reported for magnitude below two");
`endif

endmodule

`default_nettype wire

### rtl/trial_division_prime_test.sv
// channel  | signals                      | handshake
// ---------+------------------------------+-----------------------------------
// item in  | value[31:0] (signed)         | taken when start && !busy
// result   | is_prime                     | valid for one cycle while done high
//
// each trial divisor is a bound check against the running square, then a
// pass of the bit-serial remainder unit over every magnitude bit
// an item ends once a divisor divides it or the square of the divisor under
// test exceeds it; the longest searches are for primes just below 2^31
// busy is high from the edge that takes the item to the end of the done cycle
// reset is asynchronous, active low, and leaves the block idle
// the receiver cannot stall: done is a strobe, nothing waits for it
`default_nettype none

module trial_division_prime_test
    import tdp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [WIDTH-1:0] value,
    output logic                         busy,
    output logic                         done,
    output logic                         is_prime
);

    tdp_cmd_t    cmd;
    tdp_status_t status;

    tdp_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .is_prime (is_prime)
    );

    tdp_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire
